>>> rtl/core/sifc_pkg.sv
// ----------------------------------------------------------------------------
// sifc_pkg
// Shared types and constants for the smallest-items fit counter: channel
// words, sequencer states and the request/response of the shared add/compare
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sifc_pkg;

  // default sizing, handed down from the top level parameters
  localparam int MAX_ITEMS_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed field widths of the channels
  localparam int IN_WEIGHT_W = 16;
  localparam int CAP_W       = 32;
  localparam int FIT_W       = 7;
  localparam int FIT_MAX     = 127;

  // running sum never exceeds capacity plus one weight: 2^31 + 2^16 < 2^34
  localparam int SUM_W = 34;

  typedef struct packed {
    logic [IN_WEIGHT_W-1:0] item_weight;
    logic                   last_item;
  } in_word_t;

  typedef struct packed {
    logic [FIT_W-1:0] fit_count;
    logic             overflow_flag;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_CMP,
    S_SUM_RD,
    S_SUM_ACC,
    S_DONE
  } state_t;

  // shared unit: total = base + addend, over = total > bound
  typedef struct packed {
    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] addend;
    logic [SUM_W-1:0] bound;
  } unit_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             over;
  } unit_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/smallest_items_fit_count_core.sv
// ----------------------------------------------------------------------------
// smallest_items_fit_count_core
// Loads a set of weights into a sorted store by insertion, then walks the
// store from the smallest weight upward and reports how many fit within the
// signed capacity register.
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+------------------------------
//   in      | in  | in_valid / in_stall  | in_data  (weight, last flag)
//   out     | out | out_valid / out_stall| out_data (fit count, overflow)
//   cfg     | in  | cfg_valid / cfg_ready| cfg_data (capacity, signed)
//
// Input word: each stored weight larger than it is read, compared and moved up
// a cell before it drops into the hole; with the store full it is dropped.
// Last word: the capacity walk adds stored weights from the smallest up until
// the sum would exceed capacity, the store ends, or the capacity is negative.
// Synchronous active-high reset empties the store through the fill count.
// A stalled output word stays in its register while the next set loads; that
// set's result then waits in the done state with the input stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module smallest_items_fit_count_core #(
  parameter int MAX_ITEMS   = sifc_pkg::MAX_ITEMS_DEF,
  parameter int WEIGHT_BITS = sifc_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire sifc_pkg::in_word_t         in_data,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      sifc_pkg::out_word_t        out_data,
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic [sifc_pkg::CAP_W-1:0] cfg_data
);

  import sifc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int NX_W   = (CNT_W > FIT_W) ? CNT_W : FIT_W;

  state_t state, state_next;

  logic [CNT_W-1:0]       loaded_count;
  logic                   ovf_seen;
  logic [CAP_W-1:0]       cap_reg;
  logic [WEIGHT_BITS-1:0] wt;
  logic                   lst;
  logic [CNT_W-1:0]       pos;
  logic [CNT_W-1:0]       pos_dec;
  logic [CNT_W-1:0]       idx;
  logic [CNT_W-1:0]       idx_inc;
  logic [CNT_W-1:0]       n_fit;
  logic [SUM_W-1:0]       sum;

  logic                   in_accept;
  logic                   store_full;
  logic                   out_free;
  logic                   cap_neg;
  logic [NX_W-1:0]        n_ext;
  logic [FIT_W-1:0]       fit_sat;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_rdata;

  unit_req_t unit_req;
  unit_rsp_t unit_rsp;

  // sorted weight store
  sifc_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared add/compare unit
  sifc_unit u_unit (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  // handshake helpers
  assign in_accept  = in_valid && !in_stall;
  assign store_full = (loaded_count == CNT_W'(MAX_ITEMS));
  assign out_free   = !out_valid || !out_stall;
  assign cap_neg    = cap_reg[CAP_W-1];
  assign cfg_ready  = 1'b1;
  assign pos_dec    = pos - 1'b1;
  assign idx_inc    = idx + 1'b1;

  // saturate the count to the output field
  assign n_ext   = NX_W'(n_fit);
  assign fit_sat = (n_ext > NX_W'(FIT_MAX)) ? FIT_W'(FIT_MAX) : n_ext[FIT_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (!store_full) begin
            state_next = S_SHIFT_RD;
          end else if (in_data.last_item) begin
            state_next = S_SUM_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        if (pos == '0) begin
          state_next = lst ? S_SUM_RD : S_IDLE;
        end else begin
          state_next = S_SHIFT_CMP;
        end
      end
      S_SHIFT_CMP: begin
        if (unit_rsp.over) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = lst ? S_SUM_RD : S_IDLE;
        end
      end
      S_SUM_RD: begin
        if (cap_neg || (idx == loaded_count)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SUM_ACC;
        end
      end
      S_SUM_ACC: begin
        state_next = unit_rsp.over ? S_DONE : S_SUM_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: store ports and unit operands
  always_comb begin
    in_stall        = (state != S_IDLE);
    ram_we          = 1'b0;
    ram_waddr       = pos[ADDR_W-1:0];
    ram_wdata       = wt;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    unit_req.base   = '0;
    unit_req.addend = SUM_W'(ram_rdata);
    unit_req.bound  = SUM_W'(wt);
    unique case (state)
      S_IDLE: begin
      end
      S_SHIFT_RD: begin
        if (pos == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = pos_dec[ADDR_W-1:0];
        end
      end
      S_SHIFT_CMP: begin
        // move the larger entry up, or drop the new weight into the hole
        ram_we    = 1'b1;
        ram_wdata = unit_rsp.over ? ram_rdata : wt;
      end
      S_SUM_RD: begin
        if (!cap_neg && (idx != loaded_count)) begin
          ram_re    = 1'b1;
          ram_raddr = idx[ADDR_W-1:0];
        end
      end
      S_SUM_ACC: begin
        unit_req.base  = sum;
        unit_req.bound = SUM_W'(cap_reg);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      ovf_seen     <= 1'b0;
      idx          <= '0;
      n_fit        <= '0;
      sum          <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_accept && store_full) begin
            ovf_seen <= 1'b1;
          end
        end
        S_SHIFT_RD: begin
          if (pos == '0) begin
            loaded_count <= loaded_count + 1'b1;
          end
        end
        S_SHIFT_CMP: begin
          if (!unit_rsp.over) begin
            loaded_count <= loaded_count + 1'b1;
          end
        end
        S_SUM_RD: begin
        end
        S_SUM_ACC: begin
          if (!unit_rsp.over) begin
            sum   <= unit_rsp.total;
            n_fit <= idx_inc;
            idx   <= idx_inc;
          end
        end
        S_DONE: begin
          if (out_free) begin
            loaded_count <= '0;
            ovf_seen     <= 1'b0;
            idx          <= '0;
            n_fit        <= '0;
            sum          <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // insertion payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_accept) begin
      wt  <= WEIGHT_BITS'(in_data.item_weight);
      lst <= in_data.last_item;
      pos <= loaded_count;
    end else if ((state == S_SHIFT_CMP) && unit_rsp.over) begin
      pos <= pos_dec;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cap_reg <= cfg_data;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_data.fit_count     <= fit_sat;
      out_data.overflow_flag <= ovf_seen;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond store depth");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_CMP) |-> (pos != '0))
    else $error("shift compare with no lower entry");

  a_sum_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM_ACC) |-> (idx < loaded_count))
    else $error("capacity walk past the filled entries");

  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_free) |=> (out_valid && (loaded_count == '0) && !ovf_seen))
    else $error("store not emptied after result");

  a_fit_le_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (n_fit <= loaded_count))
    else $error("fit count above number of stored weights");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sifc_ram.sv
// ----------------------------------------------------------------------------
// sifc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sifc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sifc_unit.sv
// ----------------------------------------------------------------------------
// sifc_unit
// Shared add/compare unit. Used as a plain comparator during insertion
// (base zero, bound is the new weight) and as the accumulator during the
// capacity walk (base is the running sum, bound is the capacity).
// ----------------------------------------------------------------------------
`default_nettype none

module sifc_unit (
  input  wire sifc_pkg::unit_req_t req,
  output      sifc_pkg::unit_rsp_t rsp
);

  import sifc_pkg::*;

  logic [SUM_W-1:0] total;

  // one adder feeding one magnitude compare
  always_comb begin
    total     = req.base + req.addend;
    rsp.total = total;
    rsp.over  = (total > req.bound);
  end

endmodule

`default_nettype wire
